FILE: hdl/rmq_pkg.sv
// Shared types and per-stage step functions for the rotation matrix to quaternion pipeline.
// Used by rotation_matrix_to_quaternion; depends on nothing else.
package rmq_pkg;

  localparam int unsigned IN_W   = 288;
  localparam int unsigned OUT_W  = 128;
  localparam int unsigned ROOT_W = 32;
  localparam int unsigned QUO_W  = 32;
  localparam int unsigned N_SQRT = 32;
  localparam int unsigned N_DIV  = 32;
  // prep + sqrt + divider setup + divider + output formatting
  localparam int unsigned N_STG  = 1 + N_SQRT + 1 + N_DIV + 1;

  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  // output slot that carries the major component
  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_Z = 2'd2,
    SEL_W = 2'd3
  } sel_t;

  typedef struct packed {
    sel_t             sel;
    logic             bad;
    logic [2:0]       neg;
    logic [2:0][32:0] mag;
    logic [63:0]      v;
    logic [34:0]      srem;
    logic [31:0]      root;
    logic [2:0]       ovf;
    logic [2:0][33:0] drem;
    logic [2:0][31:0] quo;
    logic [3:0][31:0] q;
  } pipe_t;

  function automatic pipe_t prep(input logic [IN_W-1:0] d);
    pipe_t s;
    logic signed [34:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [34:0] tr, rad;
    logic signed [34:0] dv [3];
    s = '0;
    m00 = 35'(signed'(d[31:0]));
    m01 = 35'(signed'(d[63:32]));
    m02 = 35'(signed'(d[95:64]));
    m10 = 35'(signed'(d[127:96]));
    m11 = 35'(signed'(d[159:128]));
    m12 = 35'(signed'(d[191:160]));
    m20 = 35'(signed'(d[223:192]));
    m21 = 35'(signed'(d[255:224]));
    m22 = 35'(signed'(d[287:256]));
    tr  = m00 + m11 + m22;
    if (tr > 0) begin
      s.sel = SEL_W;
      rad   = 35'(ONE_Q30) + tr;
      dv[0] = m21 - m12;
      dv[1] = m02 - m20;
      dv[2] = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      s.sel = SEL_X;
      rad   = 35'(ONE_Q30) + m00 - m11 - m22;
      dv[0] = m01 + m10;
      dv[1] = m02 + m20;
      dv[2] = m21 - m12;
    end else if (m11 > m22) begin
      s.sel = SEL_Y;
      rad   = 35'(ONE_Q30) + m11 - m00 - m22;
      dv[0] = m01 + m10;
      dv[1] = m12 + m21;
      dv[2] = m02 - m20;
    end else begin
      s.sel = SEL_Z;
      rad   = 35'(ONE_Q30) + m22 - m00 - m11;
      dv[0] = m02 + m20;
      dv[1] = m12 + m21;
      dv[2] = m10 - m01;
    end
    s.bad = (rad <= 0);
    s.v   = s.bad ? 64'd0 : {1'b0, rad[32:0], 30'd0};
    for (int k = 0; k < 3; k++) begin
      s.neg[k] = dv[k][34];
      s.mag[k] = dv[k][34] ? 33'(-dv[k]) : dv[k][32:0];
    end
    return s;
  endfunction

  // one bit of the root per call, radicand pair p (high pairs first)
  function automatic pipe_t sqrt_step(input pipe_t si, input int p);
    pipe_t s;
    logic [34:0] rem, trial;
    s     = si;
    rem   = {si.srem[32:0], si.v[2*p +: 2]};
    trial = {1'b0, si.root, 2'b01};
    if (rem >= trial) begin
      s.srem = rem - trial;
      s.root = {si.root[30:0], 1'b1};
    end else begin
      s.srem = rem;
      s.root = {si.root[30:0], 1'b0};
    end
    return s;
  endfunction

  function automatic pipe_t div_init(input pipe_t si);
    pipe_t s;
    logic [32:0] dd;
    s  = si;
    dd = {si.root, 1'b0};
    for (int k = 0; k < 3; k++) begin
      s.ovf[k]  = ({2'b00, si.mag[k][32:2]} >= dd);
      s.drem[k] = {3'b000, si.mag[k][32:2]};
      s.quo[k]  = '0;
    end
    return s;
  endfunction

  // one quotient bit j for all three dividers
  function automatic pipe_t div_step(input pipe_t si, input int j);
    pipe_t s;
    logic [33:0] t, dd;
    logic        nb;
    s  = si;
    dd = {1'b0, si.root, 1'b0};
    for (int k = 0; k < 3; k++) begin
      nb = 1'b0;
      if (j >= 30) nb = si.mag[k][j-30];
      t = {si.drem[k][32:0], nb};
      if (t >= dd) begin
        s.drem[k]   = t - dd;
        s.quo[k][j] = 1'b1;
      end else begin
        s.drem[k]   = t;
      end
    end
    return s;
  endfunction

  function automatic pipe_t finish(input pipe_t si);
    pipe_t s;
    logic [31:0] mn [3];
    logic [31:0] mj;
    s = si;
    for (int k = 0; k < 3; k++) begin
      if (si.neg[k]) begin
        mn[k] = (si.ovf[k] || si.quo[k] > NEG_MAX) ? NEG_MAX : 32'(-si.quo[k]);
      end else begin
        mn[k] = (si.ovf[k] || si.quo[k][31]) ? POS_MAX : si.quo[k];
      end
    end
    mj = {1'b0, si.root[31:1]};
    if (si.bad) begin
      s.q = {ONE_Q30, 32'd0, 32'd0, 32'd0};
    end else begin
      unique case (si.sel)
        SEL_X:   s.q = {mn[2], mn[1], mn[0], mj};
        SEL_Y:   s.q = {mn[2], mn[1], mj, mn[0]};
        SEL_Z:   s.q = {mn[2], mj, mn[1], mn[0]};
        default: s.q = {mj, mn[2], mn[1], mn[0]};
      endcase
    end
    return s;
  endfunction

endpackage

FILE: hdl/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion, fully pipelined stream block.
// Depends on rmq_pkg for the stage record and the per-stage step functions.
//
// One matrix is taken per cycle when the output side is not stalled. The
// pipeline is the 32-stage bit-per-stage square root followed by the
// 32-stage bit-per-stage divider (three dividers sharing the root), plus
// input, setup and output stages. Every stage holds its own valid bit, so
// bubbles are squeezed out and a stalled output keeps accepting input until
// the pipeline is full.
// Non-positive radicand gives the identity quaternion with tuser set.
module rotation_matrix_to_quaternion (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2 (32 bits each)
  input  logic [rmq_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // qx, qy, qz, qw (32 bits each)
  output logic [rmq_pkg::OUT_W-1:0]   m_tdata,
  // bad_input
  output logic                        m_tuser
);

  localparam int unsigned L = rmq_pkg::N_STG;

  rmq_pkg::pipe_t stg      [L];
  rmq_pkg::pipe_t stg_next [L];
  logic [L-1:0]   vld;
  logic [L:0]     rdy;

  assign rdy[L] = m_tready;

  for (genvar i = 0; i < L; i++) begin : g_stg
    logic vin;
    assign rdy[i] = !vld[i] || rdy[i+1];

    if (i == 0) begin : g_prep
      assign vin         = s_tvalid;
      assign stg_next[i] = rmq_pkg::prep(s_tdata);
    end else if (i <= rmq_pkg::N_SQRT) begin : g_sqrt
      assign vin         = vld[i-1];
      assign stg_next[i] = rmq_pkg::sqrt_step(stg[i-1], rmq_pkg::N_SQRT - i);
    end else if (i == rmq_pkg::N_SQRT + 1) begin : g_dinit
      assign vin         = vld[i-1];
      assign stg_next[i] = rmq_pkg::div_init(stg[i-1]);
    end else if (i < L - 1) begin : g_div
      assign vin         = vld[i-1];
      assign stg_next[i] = rmq_pkg::div_step(stg[i-1], L - 2 - i);
    end else begin : g_fin
      assign vin         = vld[i-1];
      assign stg_next[i] = rmq_pkg::finish(stg[i-1]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= vin;
      end
      if (rdy[i] && vin) begin
        stg[i] <= stg_next[i];
      end
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[L-1];
  assign m_tdata  = stg[L-1].q;
  assign m_tuser  = stg[L-1].bad;

endmodule
